// ===== rtl/mma_pkg.sv =====
// Shared types and constants of the multichannel moving average block.
// Item structs, controller command and status structs, register indexes.
// No dependencies.
`timescale 1ns / 1ps

package mma_pkg;

  // fixed field widths
  localparam int unsigned NUM_CHANNELS = 3;
  localparam int unsigned CHANNEL_W    = 2;
  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned SUM_W        = 16;
  localparam int unsigned FRAC_W       = 4;
  localparam int unsigned AVG_W        = 16;
  localparam int unsigned COUNT_W      = 4;
  localparam int unsigned DIVIDEND_W   = SUM_W + FRAC_W;

  // configuration port
  localparam int unsigned CFG_LEN_W    = 5;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_ADDR_W   = 4;
  localparam logic [CFG_LEN_W-1:0] CFG_LEN_RESET = 5'd16;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WINDOW_LEN_CH0 = 2'd0;
  localparam logic [1:0] REG_WINDOW_LEN_CH1 = 2'd1;
  localparam logic [1:0] REG_WINDOW_LEN_CH2 = 2'd2;

  // item modes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] out_channel;
    logic [AVG_W-1:0]     average;
    logic [COUNT_W-1:0]   window_count;
    logic [SAMPLE_W-1:0]  raw_echo;
  } out_item_t;

  typedef logic [NUM_CHANNELS-1:0][CFG_LEN_W-1:0] cfg_lens_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic mod_step;
    logic write;
    logic sub;
    logic div_start;
    logic clear;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ch_ok;
    logic mode_clear;
    logic slot_ge_len;
    logic need_sub;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/mma_div.sv =====
// Restoring divider, one quotient bit per cycle, for the average.
// Depends on mma_pkg for the dividend width.
`timescale 1ns / 1ps

module mma_div import mma_pkg::*; #(
  parameter int unsigned DIVISOR_W = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [STEP_W-1:0]     step_q;
  logic                  busy_q;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  take;
  logic [DIVISOR_W-1:0]  rem_d;

  // one trial subtraction
  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign take    = ~diff[DIVISOR_W];
  assign rem_d   = take ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // quotient and remainder shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], take};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/mma_datapath.sv =====
// Datapath: per-channel state, sample ring memory, divider and output register.
// Depends on mma_pkg and mma_div; driven by commands from mma_ctrl.
`timescale 1ns / 1ps

module mma_datapath import mma_pkg::*; #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  cfg_lens_t  cfg_lens_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  localparam int unsigned SLOT_W    = $clog2(RING_DEPTH);
  localparam int unsigned LEN_W     = $clog2(RING_DEPTH + 1);
  localparam int unsigned CMP_W     = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
  localparam int unsigned MEM_DEPTH = NUM_CHANNELS * RING_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned CNT_EXT_W = (SLOT_W > COUNT_W) ? SLOT_W : COUNT_W;
  localparam logic [ADDR_W-1:0] RING_BASE_STEP = ADDR_W'(RING_DEPTH);

  // per-channel state
  logic [SLOT_W-1:0]   ch_slot_q [NUM_CHANNELS];
  logic [SLOT_W-1:0]   ch_fill_q [NUM_CHANNELS];
  logic [SUM_W-1:0]    ch_sum_q  [NUM_CHANNELS];
  logic [SAMPLE_W-1:0] ch_raw_q  [NUM_CHANNELS];

  // working registers of the current transaction
  logic [CHANNEL_W-1:0] ch_q;
  logic [SAMPLE_W-1:0]  smp_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [LEN_W-1:0]     len_q;
  logic [SUM_W-1:0]     sum_w_q;
  logic [SLOT_W-1:0]    cnt_w_q;
  logic [SAMPLE_W-1:0]  rd_data_q;
  logic                 res_clear_q;

  // ring memory
  logic [SAMPLE_W-1:0]  ring_mem [MEM_DEPTH];

  // output register
  logic                 out_valid_q;
  out_item_t            out_q;

  logic [CMP_W-1:0]     len_raw;
  logic [LEN_W-1:0]     len_sat;
  logic [LEN_W-1:0]     len_m1;
  logic [SLOT_W-1:0]    next_slot;
  logic [SLOT_W-1:0]    fill_cur;
  logic                 need_sub;
  logic [ADDR_W-1:0]    ch_base;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 div_busy;
  logic [DIVIDEND_W-1:0] quotient;
  logic [AVG_W-1:0]     avg_sat;
  logic [CNT_EXT_W-1:0] cnt_ext;

  // window length saturated into [2, RING_DEPTH]
  always_comb begin
    len_raw = CMP_W'(cfg_lens_i[ch_q]);
    priority if (len_raw < CMP_W'(2)) begin
      len_sat = LEN_W'(2);
    end else if (len_raw > CMP_W'(RING_DEPTH)) begin
      len_sat = LEN_W'(RING_DEPTH);
    end else begin
      len_sat = LEN_W'(len_raw);
    end
  end

  // slot advance, window fill and ring addresses
  assign len_m1    = len_q - LEN_W'(1);
  assign next_slot = ((LEN_W'(slot_q) + LEN_W'(1)) == len_q) ? '0 : slot_q + SLOT_W'(1);
  assign fill_cur  = ch_fill_q[ch_q];
  assign need_sub  = LEN_W'(fill_cur) >= len_m1;
  assign ch_base   = ADDR_W'(ch_q) * RING_BASE_STEP;
  assign wr_addr   = ch_base + ADDR_W'(slot_q);
  assign rd_addr   = ch_base + ADDR_W'(next_slot);

  // status to the controller
  always_comb begin
    status_o             = '0;
    status_o.ch_ok       = {1'b0, in_data_i.channel} < (CHANNEL_W + 1)'(NUM_CHANNELS);
    status_o.mode_clear  = in_data_i.mode == MODE_CLEAR;
    status_o.slot_ge_len = LEN_W'(slot_q) >= len_q;
    status_o.need_sub    = need_sub;
    status_o.div_busy    = div_busy;
    status_o.out_free    = ~out_valid_q | ~out_stall_i;
  end

  // per-channel state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        ch_slot_q[c] <= '0;
        ch_fill_q[c] <= '0;
        ch_sum_q[c]  <= '0;
        ch_raw_q[c]  <= '0;
      end
    end else begin
      if (cmd_i.write) begin
        ch_slot_q[ch_q] <= next_slot;
        ch_raw_q[ch_q]  <= smp_q;
      end
      if (cmd_i.div_start) begin
        ch_sum_q[ch_q]  <= sum_w_q;
        ch_fill_q[ch_q] <= cnt_w_q;
      end
      if (cmd_i.clear) begin
        ch_slot_q[ch_q] <= '0;
        ch_fill_q[ch_q] <= '0;
        ch_sum_q[ch_q]  <= '0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q  <= in_data_i.channel;
      smp_q <= in_data_i.sample;
    end
    if (cmd_i.load) begin
      slot_q <= ch_slot_q[ch_q];
      len_q  <= len_sat;
    end
    if (cmd_i.mod_step) begin
      slot_q <= SLOT_W'(LEN_W'(slot_q) - len_q);
    end
    if (cmd_i.write) begin
      sum_w_q <= ch_sum_q[ch_q] + SUM_W'(smp_q);
      cnt_w_q <= need_sub ? SLOT_W'(len_m1) : fill_cur + SLOT_W'(1);
    end
    if (cmd_i.sub) begin
      sum_w_q <= sum_w_q - SUM_W'(rd_data_q);
    end
    if (cmd_i.div_start) begin
      res_clear_q <= 1'b0;
    end
    if (cmd_i.clear) begin
      cnt_w_q     <= '0;
      res_clear_q <= 1'b1;
    end
  end

  // ring write at the current slot, read of the oldest entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      ring_mem[wr_addr] <= smp_q;
      rd_data_q         <= ring_mem[rd_addr];
    end
  end

  // sum * 16 / count
  mma_div #(
    .DIVISOR_W (SLOT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({sum_w_q, FRAC_W'(0)}),
    .divisor_i  (cnt_w_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // saturate the quotient, clear gives zero
  assign avg_sat = res_clear_q ? '0 :
                   (|quotient[DIVIDEND_W-1:AVG_W]) ? '1 : quotient[AVG_W-1:0];
  assign cnt_ext = CNT_EXT_W'(cnt_w_q);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_channel  <= ch_q;
      out_q.average      <= avg_sat;
      out_q.window_count <= cnt_ext[COUNT_W-1:0];
      out_q.raw_echo     <= ch_raw_q[ch_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // divider never sees a zero window count
  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (cnt_w_q != '0))
    else $error("divider started with zero count");

  // ring slot is reduced below the window length before the write
  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> (LEN_W'(slot_q) < len_q))
    else $error("ring write slot outside the window");
`endif

endmodule

// ===== rtl/mma_ctrl.sv =====
// Controller state machine: sequences one transaction through the datapath.
// Depends on mma_pkg for the command and status structs.
`timescale 1ns / 1ps

module mma_ctrl import mma_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_LOAD   = 9'b000000010,
    ST_MOD    = 9'b000000100,
    ST_WRITE  = 9'b000001000,
    ST_SUB    = 9'b000010000,
    ST_DSTART = 9'b000100000,
    ST_DIV    = 9'b001000000,
    ST_CLR    = 9'b010000000,
    ST_FIN    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.ch_ok) begin
          cmd_o.capture = 1'b1;
          state_d       = status_i.mode_clear ? ST_CLR : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_MOD;
      end
      ST_MOD: begin
        if (status_i.slot_ge_len) begin
          cmd_o.mod_step = 1'b1;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = status_i.need_sub ? ST_SUB : ST_DSTART;
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = ST_DSTART;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (!status_i.div_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_CLR: begin
        cmd_o.clear = 1'b1;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

`ifndef NO_ASSERTIONS
  // a waiting result is never overwritten
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free)
    else $error("output register loaded while still full");

  // divider is idle when a division starts
  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !status_i.div_busy)
    else $error("division started while divider busy");
`endif

endmodule

// ===== rtl/multichannel_moving_average.sv =====
// Top level of the multichannel moving average: configuration registers,
// controller and datapath. Depends on mma_pkg, mma_ctrl and mma_datapath.
`timescale 1ns / 1ps

// Three channels of running average over 12-bit converter samples. A sample
// transaction passes window load, slot reduction, ring write, a subtraction
// of the oldest sample once the window is full, and the 20-step restoring
// divider; slot reduction repeats while the write slot is not under a
// shortened window length. One transaction is at work at a time, and the
// next one is taken while a finished result waits on the output. Transactions
// for channel 3 are taken and dropped without a result. Window lengths are
// written through the APB port at byte addresses 0, 4 and 8 and are
// saturated into [2, RING_DEPTH]; write them only while the block is idle.

module multichannel_moving_average import mma_pkg::*; #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_lens_t  cfg_lens_q;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  // window length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        cfg_lens_q[c] <= CFG_LEN_RESET;
      end
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_WINDOW_LEN_CH0: cfg_lens_q[0] <= pwdata[CFG_LEN_W-1:0];
        REG_WINDOW_LEN_CH1: cfg_lens_q[1] <= pwdata[CFG_LEN_W-1:0];
        REG_WINDOW_LEN_CH2: cfg_lens_q[2] <= pwdata[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW_LEN_CH0: prdata = CFG_DATA_W'(cfg_lens_q[0]);
      REG_WINDOW_LEN_CH1: prdata = CFG_DATA_W'(cfg_lens_q[1]);
      REG_WINDOW_LEN_CH2: prdata = CFG_DATA_W'(cfg_lens_q[2]);
      default:            prdata = '0;
    endcase
  end

  mma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mma_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_lens_i  (cfg_lens_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
